>>> rtl/core/esc_pkg.sv
// Shared types and constants for the environmental sensor compensation block.
package esc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_PRESS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_PRESS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_MIXED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_HUMID   = 3'd4;

  // Pressure divider geometry: 64-bit magnitude over a 31-bit magnitude
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 31;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS;

  // Humidity pipeline depth
  localparam int HUM_STAGES = 10;

  // Humidity upper bound before the final shift (100 %RH)
  localparam logic [31:0] HUM_MAX = 32'd419430400;

  // Humidity trim words
  typedef struct packed {
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [15:0] h4;
    logic signed [15:0] h5;
    logic signed [7:0]  h6;
  } hum_trim_t;

endpackage

>>> rtl/core/esc_div.sv
// Pipelined restoring divider, two quotient bits per stage.
module esc_div import esc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_NUM_W-1:0] quo
);

  // nq holds the unconsumed dividend bits above the quotient bits shifted in
  logic [DIV_NUM_W-1:0] nq  [1:DIV_STAGES];
  logic [DIV_DEN_W-1:0] rem [1:DIV_STAGES-1];
  logic [DIV_DEN_W-1:0] dd  [1:DIV_STAGES-1];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DIV_NUM_W-1:0] nq_in;
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] dd_in;
    logic [DIV_NUM_W-1:0] nq_next;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;

    if (g == 0) begin : g_first
      assign nq_in  = num;
      assign rem_in = '0;
      assign dd_in  = den;
    end else begin : g_rest
      assign nq_in  = nq[g];
      assign rem_in = rem[g];
      assign dd_in  = dd[g];
    end

    // Per step, shift in one dividend bit and subtract where the divisor fits
    always_comb begin
      nq_next  = nq_in;
      rem_next = rem_in;
      trial    = '0;
      qbit     = 1'b0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        trial = {rem_next, nq_next[DIV_NUM_W-1]};
        if (trial >= {1'b0, dd_in}) begin
          rem_next = DIV_DEN_W'(trial - {1'b0, dd_in});
          qbit     = 1'b1;
        end else begin
          rem_next = trial[DIV_DEN_W-1:0];
          qbit     = 1'b0;
        end
        nq_next = {nq_next[DIV_NUM_W-2:0], qbit};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[g+1] <= nq_next;
      end
    end

    // Pass remainder and divisor on to the next stage; the last stage needs neither
    if (g < DIV_STAGES-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[g+1] <= rem_next;
          dd[g+1]  <= dd_in;
        end
      end
    end
  end

  assign quo = nq[DIV_STAGES];

endmodule

>>> rtl/core/esc_humid.sv
// Humidity compensation pipeline from the offset fine temperature.
module esc_humid import esc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [23:0] x,
  input  logic        [15:0] rh,
  input  hum_trim_t          trim,
  output logic        [16:0] humid
);

  logic        [31:0] h2_32;
  logic        [31:0] r1_h5x;
  logic        [31:0] r1_xh6;
  logic        [31:0] r1_xh3;
  logic        [15:0] r1_rh;
  logic        [31:0] ha_sum;
  logic signed [16:0] r2_ha;
  logic signed [21:0] r2_hb;
  logic signed [31:0] r2_hc;
  logic        [31:0] r3_bc;
  logic signed [16:0] r3_ha;
  logic        [31:0] r4_hd;
  logic signed [16:0] r4_ha;
  logic        [31:0] r5_dh2;
  logic signed [16:0] r5_ha;
  logic        [31:0] he_sum;
  logic signed [17:0] r6_he;
  logic signed [16:0] r6_ha;
  logic        [31:0] r7_xh;
  logic signed [16:0] s_c;
  logic        [31:0] r8_ss;
  logic        [31:0] r8_xh;
  logic        [31:0] r9_m1;
  logic        [31:0] r9_xh;
  logic        [31:0] xf;
  logic        [31:0] xc;

  assign h2_32 = 32'(trim.h2);

  // First products of the offset temperature
  always_ff @(posedge clk) begin
    if (en) begin
      r1_h5x <= x * trim.h5;
      r1_xh6 <= x * trim.h6;
      r1_xh3 <= x * $signed({1'b0, trim.h3});
      r1_rh  <= rh;
    end
  end

  assign ha_sum = {2'b0, r1_rh, 14'b0} - (32'(trim.h4) << 20) - r1_h5x + 32'd16384;

  // Offset term and the two scale factors
  always_ff @(posedge clk) begin
    if (en) begin
      r2_ha <= ha_sum[31:15];
      r2_hb <= r1_xh6[31:10];
      r2_hc <= 32'($signed(r1_xh3[31:11])) + 32'sd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_bc <= r2_hb * r2_hc;
      r3_ha <= r2_ha;
      r4_hd <= 32'($signed(r3_bc[31:10])) + 32'd2097152;
      r4_ha <= r3_ha;
      r5_dh2 <= r4_hd * h2_32;
      r5_ha  <= r4_ha;
    end
  end

  assign he_sum = r5_dh2 + 32'd8192;

  always_ff @(posedge clk) begin
    if (en) begin
      r6_he <= he_sum[31:14];
      r6_ha <= r5_ha;
      r7_xh <= r6_ha * r6_he;
    end
  end

  assign s_c = r7_xh[31:15];

  // Square correction term
  always_ff @(posedge clk) begin
    if (en) begin
      r8_ss <= s_c * s_c;
      r8_xh <= r7_xh;
      r9_m1 <= $signed(r8_ss[31:7]) * $signed({1'b0, trim.h1});
      r9_xh <= r8_xh;
    end
  end

  // Clamp to 0..100 %RH and drop the extra fraction bits
  always_comb begin
    xf = r9_xh - 32'($signed(r9_m1[31:4]));
    if (xf[31]) begin
      xc = '0;
    end else if (xf > HUM_MAX) begin
      xc = HUM_MAX;
    end else begin
      xc = xf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      humid <= xc[28:12];
    end
  end

endmodule

>>> rtl/core/environmental_sensor_compensation_top.sv
// Top level of the environmental sensor compensation pipeline.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid, in_stall   | raw_temp, raw_press, raw_humid
//   out     | output    | out_valid, out_stall | temp_centi, press_q24_8, humid_q22_10
//   cfg     | input     | cfg_wr               | cfg_idx, cfg_data
//
// One item enters per cycle unless the pipeline is held; each item reaches the output
// register through the 32-stage pressure divider plus the multiply stages.
// Reset clears the trim registers and all valid bits.
// When the output item is stalled the whole pipeline holds, and in_stall rises.
module environmental_sensor_compensation_top import esc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [19:0]          raw_temp,
  input  logic [19:0]          raw_press,
  input  logic [15:0]          raw_humid,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   temp_centi,
  output logic [31:0]          press_q24_8,
  output logic [16:0]          humid_q22_10,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [63:0]          cfg_data
);

  localparam int DIV_IN    = 11;
  localparam int OUT_STAGE = DIV_IN + DIV_STAGES + 6;
  localparam int TEMP_DLY  = OUT_STAGE - 4;
  localparam int HUM_DLY   = OUT_STAGE - 4 - HUM_STAGES;

  localparam logic [63:0] PRESS_BIAS = 64'h0000_8000_0000_0000;

  logic [47:0] trim_temp;
  logic [63:0] trim_press_a;
  logic [63:0] trim_press_b;
  logic [47:0] trim_mixed;
  logic [39:0] trim_humid;

  // Trim registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_temp    <= '0;
      trim_press_a <= '0;
      trim_press_b <= '0;
      trim_mixed   <= '0;
      trim_humid   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TRIM_TEMP:    trim_temp    <= cfg_data[47:0];
        REG_TRIM_PRESS_A: trim_press_a <= cfg_data;
        REG_TRIM_PRESS_B: trim_press_b <= cfg_data;
        REG_TRIM_MIXED:   trim_mixed   <= cfg_data[47:0];
        REG_TRIM_HUMID:   trim_humid   <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic        [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic        [31:0] p8_32, p9_32;
  hum_trim_t          htrim;

  assign t1 = trim_temp[15:0];
  assign t2 = trim_temp[31:16];
  assign t3 = trim_temp[47:32];
  assign p1 = trim_press_a[15:0];
  assign p2 = trim_press_a[31:16];
  assign p3 = trim_press_a[47:32];
  assign p4 = trim_press_a[63:48];
  assign p5 = trim_press_b[15:0];
  assign p6 = trim_press_b[31:16];
  assign p7 = trim_press_b[47:32];
  assign p8 = trim_press_b[63:48];
  assign p9 = trim_mixed[15:0];
  assign p8_32 = 32'(p8);
  assign p9_32 = 32'(p9);
  assign htrim.h1 = trim_mixed[23:16];
  assign htrim.h2 = trim_mixed[39:24];
  assign htrim.h3 = trim_mixed[47:40];
  assign htrim.h4 = trim_humid[15:0];
  assign htrim.h5 = trim_humid[31:16];
  assign htrim.h6 = trim_humid[39:32];

  // Pipeline advance: hold everything while the output item is stalled
  logic adv;
  logic [OUT_STAGE-1:0] vld;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[OUT_STAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[OUT_STAGE-2:0], in_valid};
    end
  end

  // Temperature stages
  logic signed [17:0] a_c, d_c;
  logic signed [33:0] s1_at2;
  logic signed [35:0] s1_dd;
  logic        [19:0] s1_rp, s2_rp, s3_rp, s4_rp, s5_rp, s6_rp;
  logic        [15:0] s1_rh, s2_rh, s3_rh, s4_rh;
  logic signed [31:0] at_w, dd_w, e3_w;
  logic signed [20:0] v1_c, s2_v1;
  logic signed [19:0] e_c;
  logic signed [35:0] s2_e3;
  logic signed [17:0] v2_c;
  logic signed [21:0] s3_fine;
  logic signed [31:0] f32, t5, temp_c;
  logic signed [23:0] s4_w1, s4_x;

  assign a_c = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d_c = $signed({2'b0, raw_temp[19:4]}) - $signed({2'b0, t1});

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_at2 <= a_c * t2;
      s1_dd  <= d_c * d_c;
      s1_rp  <= raw_press;
      s1_rh  <= raw_humid;
    end
  end

  assign at_w = s1_at2[31:0];
  assign dd_w = s1_dd[31:0];
  assign v1_c = 21'(at_w >>> 11);
  assign e_c  = 20'(dd_w >>> 12);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_v1 <= v1_c;
      s2_e3 <= e_c * t3;
      s2_rp <= s1_rp;
      s2_rh <= s1_rh;
    end
  end

  assign e3_w = s2_e3[31:0];
  assign v2_c = 18'(e3_w >>> 14);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fine <= 22'(s2_v1) + 22'(v2_c);
      s3_rp   <= s2_rp;
      s3_rh   <= s2_rh;
    end
  end

  assign f32    = 32'(s3_fine);
  assign t5     = (f32 <<< 2) + f32 + 32'sd128;
  assign temp_c = t5 >>> 8;

  // Offset fine temperature for pressure and humidity
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_w1 <= 24'(s3_fine) - 24'sd128000;
      s4_x  <= 24'(s3_fine) - 24'sd76800;
      s4_rp <= s3_rp;
      s4_rh <= s3_rh;
    end
  end

  // Pressure coefficient stages
  logic signed [47:0] s5_sq;
  logic signed [39:0] s5_w1p5, s5_w1p2, s6_w1p5, s6_w1p2;
  logic signed [63:0] s6_sqp6, s6_sqp3, sqp3_sh;
  logic        [63:0] s7_w2, s7_u;
  logic        [20:0] s7_pv;
  logic        [63:0] s8_n0;
  logic        [47:0] s8_upl;
  logic        [31:0] s8_uph;
  logic        [63:0] den_sum;
  logic        [43:0] s9_nl;
  logic        [31:0] s9_nh;
  logic signed [30:0] s9_den, s10_den;
  logic        [63:0] s10_num;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sq   <= s4_w1 * s4_w1;
      s5_w1p5 <= s4_w1 * p5;
      s5_w1p2 <= s4_w1 * p2;
      s5_rp   <= s4_rp;
      s6_sqp6 <= s5_sq * p6;
      s6_sqp3 <= s5_sq * p3;
      s6_w1p5 <= s5_w1p5;
      s6_w1p2 <= s5_w1p2;
      s6_rp   <= s5_rp;
    end
  end

  assign sqp3_sh = s6_sqp3 >>> 8;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_w2 <= s6_sqp6 + (64'(s6_w1p5) <<< 17) + (64'(p4) <<< 35);
      s7_u  <= sqp3_sh + (64'(s6_w1p2) <<< 12) + PRESS_BIAS;
      s7_pv <= 21'd1048576 - {1'b0, s6_rp};
    end
  end

  // Dividend and divisor, products split into 32-bit halves
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_n0  <= (64'(s7_pv) << 31) - s7_w2;
      s8_upl <= s7_u[31:0] * p1;
      s8_uph <= s7_u[63:32] * p1;
    end
  end

  assign den_sum = 64'(s8_upl) + {s8_uph, 32'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_nl   <= s8_n0[31:0] * 12'd3125;
      s9_nh   <= s8_n0[63:32] * 32'd3125;
      s9_den  <= den_sum[63:33];
      s10_num <= 64'(s9_nl) + {s9_nh, 32'b0};
      s10_den <= s9_den;
    end
  end

  // Magnitudes and sign of the quotient
  logic [DIV_NUM_W-1:0] s11_an, quo;
  logic [DIV_DEN_W-1:0] s11_ad;
  logic                 s11_neg, s11_zero;
  logic [1:0]           fdl [0:DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_an   <= s10_num[63] ? (64'd0 - s10_num) : s10_num;
      s11_ad   <= s10_den[30] ? (31'd0 - s10_den) : s10_den;
      s11_neg  <= s10_num[63] ^ s10_den[30];
      s11_zero <= (s10_den == '0);
    end
  end

  esc_div u_div (
    .clk (clk),
    .en  (adv),
    .num (s11_an),
    .den (s11_ad),
    .quo (quo)
  );

  // Carry sign and zero flags alongside the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      fdl[0] <= {s11_neg, s11_zero};
      for (int i = 1; i < DIV_STAGES; i++) begin
        fdl[i] <= fdl[i-1];
      end
    end
  end

  // Pressure correction stages
  logic [63:0]        s44_p, s45_p, s46_p, s47_p, s48_p;
  logic               s44_zero, s45_zero, s46_zero, s47_zero, s48_zero;
  logic [31:0]        sh32;
  logic [63:0]        s45_sl2;
  logic [31:0]        s45_sx;
  logic signed [48:0] s45_q2l;
  logic [31:0]        s45_q2h;
  logic [63:0]        ss_c;
  logic signed [63:0] q2sum, q2_c, s46_q2, s47_q2, s48_q2;
  logic [63:0]        s46_ss;
  logic signed [48:0] s47_l;
  logic [31:0]        s47_h;
  logic signed [63:0] q1sum, q1_c, s48_q1;
  logic [39:0]        sum40;
  logic [31:0]        press_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      s44_p    <= fdl[DIV_STAGES-1][1] ? (64'd0 - quo) : quo;
      s44_zero <= fdl[DIV_STAGES-1][0];
    end
  end

  assign sh32 = {{13{s44_p[63]}}, s44_p[63:45]};

  always_ff @(posedge clk) begin
    if (adv) begin
      s45_sl2  <= s44_p[44:13] * s44_p[44:13];
      s45_sx   <= sh32 * s44_p[44:13];
      s45_q2l  <= $signed({1'b0, s44_p[31:0]}) * p8;
      s45_q2h  <= s44_p[63:32] * p8_32;
      s45_p    <= s44_p;
      s45_zero <= s44_zero;
    end
  end

  assign ss_c  = s45_sl2 + {s45_sx[30:0], 1'b0, 32'b0};
  assign q2sum = 64'(s45_q2l) + {s45_q2h, 32'b0};
  assign q2_c  = q2sum >>> 19;

  always_ff @(posedge clk) begin
    if (adv) begin
      s46_ss   <= ss_c;
      s46_q2   <= q2_c;
      s46_p    <= s45_p;
      s46_zero <= s45_zero;
      s47_l    <= $signed({1'b0, s46_ss[31:0]}) * p9;
      s47_h    <= s46_ss[63:32] * p9_32;
      s47_q2   <= s46_q2;
      s47_p    <= s46_p;
      s47_zero <= s46_zero;
    end
  end

  assign q1sum = 64'(s47_l) + {s47_h, 32'b0};
  assign q1_c  = q1sum >>> 25;

  always_ff @(posedge clk) begin
    if (adv) begin
      s48_q1   <= q1_c;
      s48_q2   <= s47_q2;
      s48_p    <= s47_p;
      s48_zero <= s47_zero;
    end
  end

  // Only bits up to 39 of the sum reach the 32-bit result
  assign sum40   = s48_p[39:0] + s48_q1[39:0] + s48_q2[39:0];
  assign press_c = sum40[39:8] + (32'(p7) << 4);

  always_ff @(posedge clk) begin
    if (adv) begin
      press_q24_8 <= s48_zero ? 32'd0 : press_c;
    end
  end

  // Humidity
  logic [16:0] hum_c;

  esc_humid u_humid (
    .clk   (clk),
    .en    (adv),
    .x     (s4_x),
    .rh    (s4_rh),
    .trim  (htrim),
    .humid (hum_c)
  );

  // Align temperature and humidity with the pressure result
  logic signed [31:0] tdl [0:TEMP_DLY];
  logic        [16:0] hdl [0:HUM_DLY-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      tdl[0] <= temp_c;
      for (int i = 1; i <= TEMP_DLY; i++) begin
        tdl[i] <= tdl[i-1];
      end
      hdl[0] <= hum_c;
      for (int i = 1; i < HUM_DLY; i++) begin
        hdl[i] <= hdl[i-1];
      end
    end
  end

  assign temp_centi   = tdl[TEMP_DLY];
  assign humid_q22_10 = hdl[HUM_DLY-1];

endmodule
